/* src/mhvd_pkg.sv */
// mhvd_pkg: shared types for the multihash varint deframer
// phase encoding, error codes and the request record passed front to back
// no dependencies
package mhvd_pkg;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_PAY,
        PH_IDLE
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_CODE,
        ERR_TRUNC_CODE,
        ERR_LEN,
        ERR_LEN_OVER,
        ERR_TRUNC_PAY
    } t_err;

    localparam int CODE_W = 63;
    localparam int BYTE_W = 8;

    typedef struct packed {
        t_err              err;
        logic              done;
        logic              is_pay;
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] pidx;
        logic              set_code;
        logic              set_len;
        logic [CODE_W-1:0] value;
        logic              last;
    } t_req;

endpackage

/* src/multihash_varint_deframer_top.sv */
// multihash_varint_deframer_top: byte-serial multihash deframer
// parser front, two-entry request queue, result stage with output register
// depends on mhvd_pkg, mhvd_front, mhvd_queue, mhvd_back
//
// usage
//   input side is a queue write port: drive i_data_byte and i_last_of_buffer
//   with push; a byte is taken on a clock edge with push high and full low
//   result side is a queue read port: while empty is low the oldest result
//   sits on the o_ ports; it is taken on an edge with pop high
//   every accepted byte yields exactly one result
//   the code varint, length varint and digest bytes are parsed in order;
//   the byte flagged last re-arms the parser for the next buffer
// timing
//   one byte per cycle sustained while full stays low; a result reaches the
//   o_ ports through the queue write, then the output register load
// reset
//   synchronous, active low; clears the parser, queue and held code/length
// stalls
//   with pop low the output register holds, the queue fills after two more
//   bytes and then full rises until the receiver takes a result
module multihash_varint_deframer_top import mhvd_pkg::*; #(
    parameter int MAX_VARINT_BYTES = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_of_buffer,
    output logic              empty,
    input  logic              pop,
    output logic              o_is_payload,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [BYTE_W-1:0] o_payload_index,
    output logic              o_frame_done,
    output logic [2:0]        o_error_code,
    output logic [CODE_W-1:0] o_algo_code,
    output logic [BYTE_W-1:0] o_digest_len
);

    logic q_full;
    logic q_empty;
    logic q_rd;
    logic f_valid;
    t_req f_req;
    t_req q_req;

    mhvd_front #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last      (i_last_of_buffer),
        .i_q_full    (q_full),
        .o_req_valid (f_valid),
        .o_req       (f_req)
    );

    mhvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_req   (f_req),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_req   (q_req)
    );

    mhvd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_req           (q_req),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_is_payload    (o_is_payload),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_done    (o_frame_done),
        .o_error_code    (o_error_code),
        .o_algo_code     (o_algo_code),
        .o_digest_len    (o_digest_len)
    );

    assign full = q_full;

endmodule

/* src/mhvd_front.sv */
// mhvd_front: byte parser, varint decode and payload counting
// emits one classified request per accepted byte
// depends on mhvd_pkg
module mhvd_front import mhvd_pkg::*; #(
    parameter int MAX_VARINT_BYTES = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last,
    input  logic              i_q_full,
    output logic              o_req_valid,
    output t_req              o_req
);

    localparam int ACC_W = 7 * MAX_VARINT_BYTES;
    localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);
    localparam int SH_W  = (ACC_W > 1) ? $clog2(ACC_W) : 1;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [BYTE_W-1:0]   r_pcnt, n_pcnt;
    logic [BYTE_W-1:0]   r_plen, n_plen;

    logic                accept;
    logic [CNT_W-1:0]    cnt_inc;
    logic [SH_W-1:0]     sh;
    logic [ACC_W-1:0]    acc_new;
    logic [CODE_W-1:0]   val;
    logic                v_ended;
    logic                v_long;
    logic                len_over;
    logic [BYTE_W-1:0]   pcnt_inc;
    t_req                req;

    assign accept   = i_push && !i_q_full;
    assign cnt_inc  = r_cnt + 1'b1;
    assign sh       = SH_W'(int'(r_cnt) * 7);
    assign acc_new  = r_acc | (ACC_W'(i_data_byte[6:0]) << sh);
    assign val      = CODE_W'(acc_new);
    assign v_ended  = !i_data_byte[7];
    assign v_long   = i_data_byte[7] && (cnt_inc == CNT_W'(MAX_VARINT_BYTES));
    assign len_over = |val[CODE_W-1:BYTE_W];
    assign pcnt_inc = r_pcnt + 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (i_last) begin
                n_phase = PH_CODE;
            end else begin
                unique case (r_phase)
                    PH_CODE: begin
                        if (v_ended) begin
                            n_phase = PH_LEN;
                        end else if (v_long) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_LEN: begin
                        if (v_ended) begin
                            if (len_over || (val[BYTE_W-1:0] == '0)) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_PAY;
                            end
                        end else if (v_long) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_PAY: begin
                        if (pcnt_inc == r_plen) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // request and datapath updates
    always_comb begin
        req    = '0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_pcnt = r_pcnt;
        n_plen = r_plen;
        if (accept) begin
            req.last = i_last;
            unique case (r_phase)
                PH_CODE: begin
                    n_cnt = cnt_inc;
                    n_acc = acc_new;
                    if (v_ended) begin
                        n_cnt        = '0;
                        n_acc        = '0;
                        req.set_code = 1'b1;
                        req.value    = val;
                        if (i_last) begin
                            req.err = ERR_TRUNC_CODE;
                        end
                    end else if (v_long || i_last) begin
                        req.err = ERR_CODE;
                    end
                end
                PH_LEN: begin
                    n_cnt = cnt_inc;
                    n_acc = acc_new;
                    if (v_ended) begin
                        n_cnt = '0;
                        n_acc = '0;
                        if (len_over) begin
                            req.err = ERR_LEN_OVER;
                        end else begin
                            req.set_len = 1'b1;
                            req.value   = val;
                            n_plen      = val[BYTE_W-1:0];
                            n_pcnt      = '0;
                            if (val[BYTE_W-1:0] == '0) begin
                                req.done = 1'b1;
                            end else if (i_last) begin
                                req.err = ERR_TRUNC_PAY;
                            end
                        end
                    end else if (v_long || i_last) begin
                        req.err = ERR_LEN;
                    end
                end
                PH_PAY: begin
                    req.is_pay = 1'b1;
                    req.pbyte  = i_data_byte;
                    req.pidx   = r_pcnt;
                    n_pcnt     = pcnt_inc;
                    if (pcnt_inc == r_plen) begin
                        req.done = 1'b1;
                    end else if (i_last) begin
                        req.err = ERR_TRUNC_PAY;
                    end
                end
                PH_IDLE: begin
                    req.last = i_last;
                end
                default: begin
                    req.last = i_last;
                end
            endcase
            if (i_last) begin
                n_cnt  = '0;
                n_acc  = '0;
                n_pcnt = '0;
                n_plen = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_pcnt  <= '0;
            r_plen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_pcnt  <= n_pcnt;
            r_plen  <= n_plen;
        end
    end

    assign o_req_valid = accept;
    assign o_req       = req;

endmodule

/* src/mhvd_queue.sv */
// mhvd_queue: two-entry request queue between parser and result stage
// lets either side stall without holding the other
// depends on mhvd_pkg
module mhvd_queue import mhvd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_req i_req,
    input  logic i_rd,
    output logic o_full,
    output logic o_empty,
    output t_req o_req
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_ok;
    logic       rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= !r_wp;
            end
            if (rd_ok) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr_ok) - 2'(rd_ok);
        end
    end

endmodule

/* src/mhvd_back.sv */
// mhvd_back: result stage, keeps the held code and length and builds results
// output register presented queue-style to the receiver
// depends on mhvd_pkg
module mhvd_back import mhvd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_req              i_req,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_is_payload,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [BYTE_W-1:0] o_payload_index,
    output logic              o_frame_done,
    output logic [2:0]        o_error_code,
    output logic [CODE_W-1:0] o_algo_code,
    output logic [BYTE_W-1:0] o_digest_len
);

    logic              r_valid;
    logic [CODE_W-1:0] r_held_code;
    logic [BYTE_W-1:0] r_held_len;
    logic              r_is_pay;
    logic [BYTE_W-1:0] r_pbyte;
    logic [BYTE_W-1:0] r_pidx;
    logic              r_done;
    logic [2:0]        r_err;
    logic [CODE_W-1:0] r_code;
    logic [BYTE_W-1:0] r_len;

    logic              take;
    logic [CODE_W-1:0] code_now;
    logic [BYTE_W-1:0] len_now;

    assign take     = !i_q_empty && (!r_valid || i_pop);
    assign code_now = i_req.set_code ? i_req.value : r_held_code;
    assign len_now  = i_req.set_len ? i_req.value[BYTE_W-1:0] : r_held_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_held_code <= '0;
            r_held_len  <= '0;
        end else begin
            if (take) begin
                r_valid     <= 1'b1;
                r_held_code <= i_req.last ? '0 : code_now;
                r_held_len  <= i_req.last ? '0 : len_now;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_is_pay <= i_req.is_pay;
            r_pbyte  <= i_req.pbyte;
            r_pidx   <= i_req.pidx;
            r_done   <= i_req.done;
            r_err    <= i_req.err;
            r_code   <= code_now;
            r_len    <= len_now;
        end
    end

    assign o_q_rd          = take;
    assign o_empty         = !r_valid;
    assign o_is_payload    = r_is_pay;
    assign o_payload_byte  = r_pbyte;
    assign o_payload_index = r_pidx;
    assign o_frame_done    = r_done;
    assign o_error_code    = r_err;
    assign o_algo_code     = r_code;
    assign o_digest_len    = r_len;

endmodule

/* src/mhvd_checker.sv */
// mhvd_checker: port-level checks on the deframer results
// bound to multihash_varint_deframer_top
// depends on nothing but the top level's ports
module mhvd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_is_payload,
    input logic [7:0] o_payload_byte,
    input logic [7:0] o_payload_index,
    input logic       o_frame_done,
    input logic [2:0] o_error_code
);

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_TRUNC_PAY = 3'd5;

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_done |-> o_error_code == E_NONE)
        else $error("frame done together with an error");

    a_pay_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_is_payload |->
            (o_error_code == E_NONE || o_error_code == E_TRUNC_PAY))
        else $error("digest byte with a header error");

    a_non_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_is_payload |-> o_payload_byte == 8'd0 && o_payload_index == 8'd0)
        else $error("payload fields set on a non-digest result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(!empty && !pop) |->
            !empty && $stable(o_payload_byte) && $stable(o_error_code))
        else $error("stalled request changed");

endmodule

bind multihash_varint_deframer_top mhvd_checker u_mhvd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_is_payload    (o_is_payload),
    .o_payload_byte  (o_payload_byte),
    .o_payload_index (o_payload_index),
    .o_frame_done    (o_frame_done),
    .o_error_code    (o_error_code)
);
